// ===== rtl/pesr_pkg.sv =====
// Shared constants, opcodes and beat structures for the event queue with slot rotation.
package pesr_pkg;

  // Queue and flash geometry.
  localparam int MAX_RECORDS    = 2;
  localparam int SLOTS_PER_PAGE = 8;

  // Fixed field widths of the ports.
  localparam int OP_W      = 2;
  localparam int ID_W      = 32;
  localparam int PAY_W     = 64;
  localparam int INDEX_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int OUT_SLOT_W = 4;

  // Derived internal widths.
  localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
  localparam int SLOT_W = $clog2(SLOTS_PER_PAGE);

  // Command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_GET     = 2'd3
  } op_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic               is_enq;
    logic               is_rem;
    logic               is_clr;
    logic               is_get;
    logic [ID_W-1:0]    evt_id;
    logic [PAY_W-1:0]   payload;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic                  ok;
    logic [ID_W-1:0]       assigned_id;
    logic [ID_W-1:0]       read_id;
    logic [PAY_W-1:0]      read_payload;
    logic                  dropped_oldest;
    logic [COUNT_W-1:0]    entry_count;
    logic [ID_W-1:0]       snapshot_generation;
    logic                  snapshot_page;
    logic [OUT_SLOT_W-1:0] snapshot_slot;
    logic                  page_erased;
  } rsp_t;

endpackage

// ===== rtl/pesr_front.sv =====
// Front part: accepts input beats, decodes the opcode and buffers commands in a short queue.
module pesr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [pesr_pkg::OP_W-1:0]      in_opcode,
  input  logic [pesr_pkg::ID_W-1:0]      in_evt_id,
  input  logic [pesr_pkg::PAY_W-1:0]     in_payload,
  input  logic [pesr_pkg::INDEX_W-1:0]   in_index,
  output logic                           cmd_valid,
  output pesr_pkg::cmd_t                 cmd,
  input  logic                           cmd_ready
);

  pesr_pkg::cmd_t                      cmdq_r [pesr_pkg::CMDQ_DEPTH];
  logic [pesr_pkg::CMDQ_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [pesr_pkg::CMDQ_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [pesr_pkg::CMDQ_CNT_W-1:0]     cnt_r, cnt_nxt;
  pesr_pkg::cmd_t                      dec;
  logic                                push_ok;
  logic                                pop_ok;

  // Decode the opcode into one-hot class flags.
  always_comb begin
    dec          = '0;
    dec.evt_id   = in_evt_id;
    dec.payload  = in_payload;
    dec.index    = in_index;
    unique case (pesr_pkg::op_t'(in_opcode))
      pesr_pkg::OP_ENQUEUE: dec.is_enq = 1'b1;
      pesr_pkg::OP_REMOVE:  dec.is_rem = 1'b1;
      pesr_pkg::OP_CLEAR:   dec.is_clr = 1'b1;
      pesr_pkg::OP_GET:     dec.is_get = 1'b1;
      default:              dec.is_get = 1'b0;
    endcase
  end

  // Queue status and handshakes.
  assign in_full   = (cnt_r == pesr_pkg::CMDQ_CNT_W'(pesr_pkg::CMDQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = cmdq_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_valid && cmd_ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == pesr_pkg::CMDQ_PTR_W'(pesr_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == pesr_pkg::CMDQ_PTR_W'(pesr_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      cmdq_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== rtl/pesr_back.sv =====
// Back part: holds the event queue and snapshot state, executes commands and registers results.
module pesr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  pesr_pkg::cmd_t cmd,
  output logic           cmd_ready,
  output logic           rsp_valid,
  output pesr_pkg::rsp_t rsp,
  input  logic           rsp_pop
);

  // Architectural state.
  logic [pesr_pkg::ID_W-1:0]           ids_r  [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::PAY_W-1:0]          pays_r [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::CNT_W-1:0]          count_r;
  logic [pesr_pkg::ID_W-1:0]           gen_r;
  logic                                page_r;
  logic [pesr_pkg::SLOT_W-1:0]         slot_r;
  logic                                slot_valid_r;
  logic [pesr_pkg::SLOTS_PER_PAGE-1:0] used_r [2];

  // Next values.
  logic [pesr_pkg::ID_W-1:0]           ids_nxt  [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::PAY_W-1:0]          pays_nxt [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::CNT_W-1:0]          count_nxt;
  logic [pesr_pkg::SLOTS_PER_PAGE-1:0] used_nxt [2];

  // Output register.
  logic           rsp_valid_r;
  pesr_pkg::rsp_t rsp_r, rsp_nxt;

  // Working signals.
  logic                                take;
  logic                                full;
  logic [pesr_pkg::ID_W-1:0]           gen_plus1;
  logic [pesr_pkg::ID_W-1:0]           enq_id;
  logic [pesr_pkg::ID_W-1:0]           enq_ids  [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::PAY_W-1:0]          enq_pays [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::ID_W-1:0]           rem_ids  [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::PAY_W-1:0]          rem_pays [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::MAX_RECORDS-1:0]    keep;
  logic [pesr_pkg::CNT_W-1:0]          pos_at [pesr_pkg::MAX_RECORDS];
  logic [pesr_pkg::CNT_W-1:0]          kept;
  logic                                found;
  logic                                get_ok;
  logic [pesr_pkg::ID_W-1:0]           get_id;
  logic [pesr_pkg::PAY_W-1:0]          get_pay;
  logic                                do_save;
  logic [pesr_pkg::SLOT_W:0]           slot_next;
  logic                                stay;
  logic                                tgt_page;
  logic [pesr_pkg::SLOT_W-1:0]         tgt_slot;
  logic                                erase;

  assign take      = cmd_valid && cmd_ready;
  assign cmd_ready = !rsp_valid_r || rsp_pop;
  assign rsp_valid = rsp_valid_r;
  assign rsp       = rsp_r;
  assign full      = (count_r == pesr_pkg::CNT_W'(pesr_pkg::MAX_RECORDS));
  assign gen_plus1 = gen_r + 1'b1;

  // A zero id on enqueue takes generation plus one, skipping zero.
  always_comb begin
    enq_id = cmd.evt_id;
    if (cmd.evt_id == '0) begin
      enq_id = (gen_plus1 == '0) ? pesr_pkg::ID_W'(1) : gen_plus1;
    end
  end

  // Enqueue contents: append, or shift out the oldest when full.
  always_comb begin
    for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
      enq_ids[k]  = ids_r[k];
      enq_pays[k] = pays_r[k];
      if (!full && (pesr_pkg::CNT_W'(k) == count_r)) begin
        enq_ids[k]  = enq_id;
        enq_pays[k] = cmd.payload;
      end
    end
    if (full) begin
      for (int k = 0; k < pesr_pkg::MAX_RECORDS - 1; k++) begin
        enq_ids[k]  = ids_r[k + 1];
        enq_pays[k] = pays_r[k + 1];
      end
      enq_ids[pesr_pkg::MAX_RECORDS - 1]  = enq_id;
      enq_pays[pesr_pkg::MAX_RECORDS - 1] = cmd.payload;
    end
  end

  // Remove: mark survivors, number them by prefix count and compact them.
  always_comb begin
    found = 1'b0;
    kept  = '0;
    for (int i = 0; i < pesr_pkg::MAX_RECORDS; i++) begin
      keep[i]   = (pesr_pkg::CNT_W'(i) < count_r) && (ids_r[i] != cmd.evt_id);
      found     = found | ((pesr_pkg::CNT_W'(i) < count_r) && (ids_r[i] == cmd.evt_id));
      pos_at[i] = kept;
      if (keep[i]) begin
        kept = kept + 1'b1;
      end
    end
    for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
      rem_ids[k]  = '0;
      rem_pays[k] = '0;
      for (int i = 0; i < pesr_pkg::MAX_RECORDS; i++) begin
        if (keep[i] && (pos_at[i] == pesr_pkg::CNT_W'(k))) begin
          rem_ids[k]  = ids_r[i];
          rem_pays[k] = pays_r[i];
        end
      end
    end
  end

  // Get: range check and selection by index.
  always_comb begin
    get_ok  = (pesr_pkg::COUNT_W'(cmd.index) < pesr_pkg::COUNT_W'(count_r));
    get_id  = '0;
    get_pay = '0;
    for (int i = 0; i < pesr_pkg::MAX_RECORDS; i++) begin
      if (get_ok && (cmd.index == pesr_pkg::INDEX_W'(i))) begin
        get_id  = ids_r[i];
        get_pay = pays_r[i];
      end
    end
  end

  // Slot rotation: next slot on this page, else slot zero of the other page.
  assign do_save   = cmd.is_enq || cmd.is_clr || (cmd.is_rem && found);
  assign slot_next = {1'b0, slot_r} + 1'b1;
  assign stay      = slot_valid_r &&
                     (slot_next < (pesr_pkg::SLOT_W + 1)'(pesr_pkg::SLOTS_PER_PAGE)) &&
                     !used_r[page_r][slot_next[pesr_pkg::SLOT_W-1:0]];
  assign tgt_page  = stay ? page_r : !page_r;
  assign tgt_slot  = stay ? slot_next[pesr_pkg::SLOT_W-1:0] : '0;
  assign erase     = !stay && used_r[!page_r][0];

  // Next state of the queue and the used-slot map.
  always_comb begin
    for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
      ids_nxt[k]  = ids_r[k];
      pays_nxt[k] = pays_r[k];
    end
    count_nxt   = count_r;
    used_nxt[0] = used_r[0];
    used_nxt[1] = used_r[1];
    if (cmd.is_enq) begin
      for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
        ids_nxt[k]  = enq_ids[k];
        pays_nxt[k] = enq_pays[k];
      end
      count_nxt = full ? count_r : count_r + 1'b1;
    end else if (cmd.is_rem && found) begin
      for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
        ids_nxt[k]  = rem_ids[k];
        pays_nxt[k] = rem_pays[k];
      end
      count_nxt = kept;
    end else if (cmd.is_clr) begin
      for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
        ids_nxt[k]  = '0;
        pays_nxt[k] = '0;
      end
      count_nxt = '0;
    end
    if (erase) begin
      used_nxt[tgt_page] = pesr_pkg::SLOTS_PER_PAGE'(1);
    end else begin
      used_nxt[tgt_page] = used_r[tgt_page] | (pesr_pkg::SLOTS_PER_PAGE'(1) << tgt_slot);
    end
  end

  // Result beat, showing the state after the operation.
  always_comb begin
    rsp_nxt                     = '0;
    rsp_nxt.ok                  = do_save || (cmd.is_get && get_ok);
    rsp_nxt.assigned_id         = cmd.is_enq ? enq_id : '0;
    rsp_nxt.read_id             = cmd.is_get ? get_id : '0;
    rsp_nxt.read_payload        = cmd.is_get ? get_pay : '0;
    rsp_nxt.dropped_oldest      = cmd.is_enq && full;
    rsp_nxt.entry_count         = pesr_pkg::COUNT_W'(do_save ? count_nxt : count_r);
    rsp_nxt.snapshot_generation = do_save ? gen_plus1 : gen_r;
    rsp_nxt.snapshot_page       = do_save ? tgt_page : page_r;
    rsp_nxt.snapshot_slot       = pesr_pkg::OUT_SLOT_W'(do_save ? tgt_slot : slot_r);
    rsp_nxt.page_erased         = do_save && erase;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
        ids_r[k]  <= '0;
        pays_r[k] <= '0;
      end
      count_r      <= '0;
      gen_r        <= '0;
      page_r       <= 1'b0;
      slot_r       <= '0;
      slot_valid_r <= 1'b0;
      used_r[0]    <= '0;
      used_r[1]    <= '0;
      rsp_valid_r  <= 1'b0;
    end else begin
      if (take && do_save) begin
        for (int k = 0; k < pesr_pkg::MAX_RECORDS; k++) begin
          ids_r[k]  <= ids_nxt[k];
          pays_r[k] <= pays_nxt[k];
        end
        count_r      <= count_nxt;
        gen_r        <= gen_plus1;
        page_r       <= tgt_page;
        slot_r       <= tgt_slot;
        slot_valid_r <= 1'b1;
        used_r[0]    <= used_nxt[0];
        used_r[1]    <= used_nxt[1];
      end
      if (take) begin
        rsp_valid_r <= 1'b1;
      end else if (rsp_pop) begin
        rsp_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      rsp_r <= rsp_nxt;
    end
  end

endmodule

// ===== rtl/persistent_event_queue_slot_rotation_unit.sv =====
// Top level of the event queue with two-page snapshot slot rotation.
//
//   channel  | handshake          | beat
//   ---------+--------------------+------------------------------------------------
//   in_      | in_push / in_full  | opcode, evt_id, payload, index
//   out_     | out_pop / out_empty| ok, ids, payload, count, generation, page, slot
//
// A beat is decoded into a two-entry command queue and executed by the back part, whose
// result is registered; one operation per cycle is sustained while results are popped.
// The back part executes only when its result register is free or being popped.
// A stall on the result side fills the command queue, then raises in_full.
// Synchronous active-low reset empties both queues and restores the initial snapshot state.
module persistent_event_queue_slot_rotation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [pesr_pkg::OP_W-1:0]         in_opcode,
  input  logic [pesr_pkg::ID_W-1:0]         in_evt_id,
  input  logic [pesr_pkg::PAY_W-1:0]        in_payload,
  input  logic [pesr_pkg::INDEX_W-1:0]      in_index,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_ok,
  output logic [pesr_pkg::ID_W-1:0]         out_assigned_id,
  output logic [pesr_pkg::ID_W-1:0]         out_read_id,
  output logic [pesr_pkg::PAY_W-1:0]        out_read_payload,
  output logic                              out_dropped_oldest,
  output logic [pesr_pkg::COUNT_W-1:0]      out_entry_count,
  output logic [pesr_pkg::ID_W-1:0]         out_snapshot_generation,
  output logic                              out_snapshot_page,
  output logic [pesr_pkg::OUT_SLOT_W-1:0]   out_snapshot_slot,
  output logic                              out_page_erased
);

  logic           cmd_valid;
  logic           cmd_ready;
  pesr_pkg::cmd_t cmd;
  logic           rsp_valid;
  pesr_pkg::rsp_t rsp;

  // Front: accept and classify.
  pesr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_opcode  (in_opcode),
    .in_evt_id  (in_evt_id),
    .in_payload (in_payload),
    .in_index   (in_index),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_ready  (cmd_ready)
  );

  // Back: execute and hold the result.
  pesr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .rsp_valid(rsp_valid),
    .rsp      (rsp),
    .rsp_pop  (out_pop)
  );

  // Result ports.
  assign out_empty               = !rsp_valid;
  assign out_ok                  = rsp.ok;
  assign out_assigned_id         = rsp.assigned_id;
  assign out_read_id             = rsp.read_id;
  assign out_read_payload        = rsp.read_payload;
  assign out_dropped_oldest      = rsp.dropped_oldest;
  assign out_entry_count         = rsp.entry_count;
  assign out_snapshot_generation = rsp.snapshot_generation;
  assign out_snapshot_page       = rsp.snapshot_page;
  assign out_snapshot_slot       = rsp.snapshot_slot;
  assign out_page_erased         = rsp.page_erased;

endmodule

// ===== rtl/pesr_checker.sv =====
// Port-level checker for the event queue top level, attached by bind.
module pesr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic                              out_ok,
  input logic                              out_dropped_oldest,
  input logic [pesr_pkg::COUNT_W-1:0]      out_entry_count,
  input logic [pesr_pkg::ID_W-1:0]         out_snapshot_generation,
  input logic [pesr_pkg::OUT_SLOT_W-1:0]   out_snapshot_slot,
  input logic                              out_page_erased
);

  // Reset leaves both sides empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result beat holds until popped.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_snapshot_generation) &&
                                 $stable(out_entry_count) && $stable(out_ok))
    else $error("result beat changed while waiting");

  // The queue never reports more entries than it holds.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_entry_count <= pesr_pkg::COUNT_W'(pesr_pkg::MAX_RECORDS))
    else $error("entry count above capacity");

  // Dropping the oldest entry happens only on a successful enqueue into a full queue.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_dropped_oldest) |->
      out_ok && out_entry_count == pesr_pkg::COUNT_W'(pesr_pkg::MAX_RECORDS))
    else $error("drop reported without a full queue");

  // An erase always targets slot zero of a successful save.
  a_erase_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_page_erased) |-> out_ok && out_snapshot_slot == '0)
    else $error("page erase without a save to slot zero");

endmodule

bind persistent_event_queue_slot_rotation_unit pesr_checker u_pesr_checker (.*);

// ===== tb/sv/persistent_event_queue_slot_rotation_unit_tb.sv =====
// Self-checking testbench for the event queue with two-page snapshot slot rotation.
`timescale 1ns / 100ps

module persistent_event_queue_slot_rotation_unit_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BEATS  = 310;
  localparam int HOLDOFF_LEN   = 60;
  localparam int DRAIN_CYCLES  = 8;

  // Mirror of the queue contents and the flash slot rotation; it predicts each result beat.
  class event_queue_scoreboard;
    logic [pesr_pkg::ID_W-1:0]           ids [pesr_pkg::MAX_RECORDS];
    logic [pesr_pkg::PAY_W-1:0]          pays [pesr_pkg::MAX_RECORDS];
    int                                  count;
    logic [pesr_pkg::ID_W-1:0]           gen;
    logic                                page;
    int                                  slot;
    bit                                  slot_valid;
    logic [pesr_pkg::SLOTS_PER_PAGE-1:0] used [2];
    pesr_pkg::rsp_t                      expected_q [$];
    int                                  errors;
    int                                  results;
    int                                  drops;
    int                                  erases;
    int                                  op_seen [4];

    function new();
      for (int i = 0; i < pesr_pkg::MAX_RECORDS; i++) begin
        ids[i] = '0;
        pays[i] = '0;
      end
      count = 0;
      gen = '0;
      page = 1'b0;
      slot = 0;
      slot_valid = 1'b0;
      used[0] = '0;
      used[1] = '0;
      errors = 0;
      results = 0;
      drops = 0;
      erases = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Id currently held at a queue position, used to aim removes at live entries.
    function logic [pesr_pkg::ID_W-1:0] held_id(int pos);
      return ids[pos];
    endfunction

    // Commit a new snapshot to the next slot; returns 1 when the target page was erased.
    function bit commit_snapshot(logic [pesr_pkg::ID_W-1:0] nids [pesr_pkg::MAX_RECORDS],
                                 logic [pesr_pkg::PAY_W-1:0] npays [pesr_pkg::MAX_RECORDS],
                                 int n);
      logic next_page;
      int   next_slot;
      bit   erased;
      next_page = page;
      next_slot = slot + 1;
      erased = 1'b0;
      if (!slot_valid || next_slot >= pesr_pkg::SLOTS_PER_PAGE || used[page][next_slot]) begin
        next_page = ~page;
        next_slot = 0;
        if (used[next_page][0]) begin
          used[next_page] = '0;
          erased = 1'b1;
        end
      end
      used[next_page][next_slot] = 1'b1;
      for (int i = 0; i < pesr_pkg::MAX_RECORDS; i++) begin
        ids[i] = (i < n) ? nids[i] : '0;
        pays[i] = (i < n) ? npays[i] : '0;
      end
      count = n;
      gen = gen + 1;
      page = next_page;
      slot = next_slot;
      slot_valid = 1'b1;
      return erased;
    endfunction

    // Note one accepted input beat and queue the result it must produce.
    function void note_input(pesr_pkg::op_t op, logic [pesr_pkg::ID_W-1:0] id,
                             logic [pesr_pkg::PAY_W-1:0] pay,
                             logic [pesr_pkg::INDEX_W-1:0] idx);
      pesr_pkg::rsp_t             want;
      logic [pesr_pkg::ID_W-1:0]  nids [pesr_pkg::MAX_RECORDS];
      logic [pesr_pkg::PAY_W-1:0] npays [pesr_pkg::MAX_RECORDS];
      int                         n;
      int                         k;
      bit                         found;
      want = '0;
      nids = ids;
      npays = pays;
      n = (count > pesr_pkg::MAX_RECORDS) ? pesr_pkg::MAX_RECORDS : count;
      op_seen[op]++;
      case (op)
        pesr_pkg::OP_ENQUEUE: begin
          if (id == '0) begin
            id = gen + 1;
            if (id == '0) id = pesr_pkg::ID_W'(1);
          end
          if (n < pesr_pkg::MAX_RECORDS) begin
            nids[n] = id;
            npays[n] = pay;
            n++;
          end else begin
            for (int i = 0; i + 1 < n; i++) begin
              nids[i] = nids[i+1];
              npays[i] = npays[i+1];
            end
            nids[n-1] = id;
            npays[n-1] = pay;
            want.dropped_oldest = 1'b1;
          end
          want.assigned_id = id;
          want.page_erased = commit_snapshot(nids, npays, n);
          want.ok = 1'b1;
        end
        pesr_pkg::OP_REMOVE: begin
          k = 0;
          found = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (ids[i] == id) begin
              found = 1'b1;
            end else begin
              nids[k] = ids[i];
              npays[k] = pays[i];
              k++;
            end
          end
          if (found) begin
            want.page_erased = commit_snapshot(nids, npays, k);
            want.ok = 1'b1;
          end
        end
        pesr_pkg::OP_CLEAR: begin
          want.page_erased = commit_snapshot(nids, npays, 0);
          want.ok = 1'b1;
        end
        default: begin
          if (idx < n) begin
            want.read_id = ids[idx];
            want.read_payload = pays[idx];
            want.ok = 1'b1;
          end
        end
      endcase
      want.entry_count = pesr_pkg::COUNT_W'(count);
      want.snapshot_generation = gen;
      want.snapshot_page = page;
      want.snapshot_slot = pesr_pkg::OUT_SLOT_W'(slot);
      if (want.dropped_oldest) drops++;
      if (want.page_erased) erases++;
      expected_q.push_back(want);
    endfunction

    function string show(pesr_pkg::rsp_t r);
      return $sformatf({"ok=%0b aid=%h rid=%h rpay=%h drop=%0b cnt=%0d gen=%h ",
                        "page=%0b slot=%0d erased=%0b"},
                       r.ok, r.assigned_id, r.read_id, r.read_payload, r.dropped_oldest,
                       r.entry_count, r.snapshot_generation, r.snapshot_page,
                       r.snapshot_slot, r.page_erased);
    endfunction

    // Compare one popped result beat with the oldest expectation.
    function void check_result(pesr_pkg::rsp_t got);
      pesr_pkg::rsp_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat with nothing expected: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result beat %0d differs", results);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic                            in_full;
  logic [pesr_pkg::OP_W-1:0]       in_opcode = '0;
  logic [pesr_pkg::ID_W-1:0]       in_evt_id = '0;
  logic [pesr_pkg::PAY_W-1:0]      in_payload = '0;
  logic [pesr_pkg::INDEX_W-1:0]    in_index = '0;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic                            out_ok;
  logic [pesr_pkg::ID_W-1:0]       out_assigned_id;
  logic [pesr_pkg::ID_W-1:0]       out_read_id;
  logic [pesr_pkg::PAY_W-1:0]      out_read_payload;
  logic                            out_dropped_oldest;
  logic [pesr_pkg::COUNT_W-1:0]    out_entry_count;
  logic [pesr_pkg::ID_W-1:0]       out_snapshot_generation;
  logic                            out_snapshot_page;
  logic [pesr_pkg::OUT_SLOT_W-1:0] out_snapshot_slot;
  logic                            out_page_erased;

  event_queue_scoreboard sb = new();
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  int holdoff_requests = 0;
  int cycles = 0;

  persistent_event_queue_slot_rotation_unit dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_opcode               (in_opcode),
    .in_evt_id               (in_evt_id),
    .in_payload              (in_payload),
    .in_index                (in_index),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_ok                  (out_ok),
    .out_assigned_id         (out_assigned_id),
    .out_read_id             (out_read_id),
    .out_read_payload        (out_read_payload),
    .out_dropped_oldest      (out_dropped_oldest),
    .out_entry_count         (out_entry_count),
    .out_snapshot_generation (out_snapshot_generation),
    .out_snapshot_page       (out_snapshot_page),
    .out_snapshot_slot       (out_snapshot_slot),
    .out_page_erased         (out_page_erased)
  );

  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               sb.outstanding());
      $display("persistent_event_queue_slot_rotation_unit: mismatch");
      $finish;
    end
  end

  // Offer one beat and hold it until the block takes it.
  task automatic push_beat(pesr_pkg::op_t op, logic [pesr_pkg::ID_W-1:0] id,
                           logic [pesr_pkg::PAY_W-1:0] pay,
                           logic [pesr_pkg::INDEX_W-1:0] idx);
    in_push <= 1'b1;
    in_opcode <= op;
    in_evt_id <= id;
    in_payload <= pay;
    in_index <= idx;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(op, id, pay, idx);
  endtask

  task automatic idle_gap(int n);
    in_push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering beats until every expected result has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Random beat, mostly aimed at live ids and valid positions so removes and gets hit.
  task automatic random_beat();
    int                           r;
    pesr_pkg::op_t                op;
    logic [pesr_pkg::ID_W-1:0]    id;
    logic [pesr_pkg::PAY_W-1:0]   pay;
    logic [pesr_pkg::INDEX_W-1:0] idx;
    r = $urandom_range(99);
    if (r < 40) op = pesr_pkg::OP_ENQUEUE;
    else if (r < 62) op = pesr_pkg::OP_REMOVE;
    else if (r < 72) op = pesr_pkg::OP_CLEAR;
    else op = pesr_pkg::OP_GET;
    case ($urandom_range(3))
      0: id = '0;
      1: id = pesr_pkg::ID_W'($urandom_range(4, 1));
      2: id = sb.held_id($urandom_range(pesr_pkg::MAX_RECORDS - 1));
      default: id = $urandom;
    endcase
    pay = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      idx = pesr_pkg::INDEX_W'($urandom_range(15));
    end else begin
      idx = pesr_pkg::INDEX_W'($urandom_range(pesr_pkg::MAX_RECORDS));
    end
    // Each idle cycle is drawn on its own, so the idle share of cycles follows the rate.
    while ($urandom_range(99) < sender_idle_pct) idle_gap(1);
    push_beat(op, id, pay, idx);
  endtask

  // Result side: check every popped beat, then pick the next pop value.
  initial begin
    int holdoff_left;
    int holdoffs_seen;
    pesr_pkg::rsp_t got;
    holdoff_left = 0;
    holdoffs_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got = '{ok: out_ok, assigned_id: out_assigned_id, read_id: out_read_id,
                read_payload: out_read_payload, dropped_oldest: out_dropped_oldest,
                entry_count: out_entry_count, snapshot_generation: out_snapshot_generation,
                snapshot_page: out_snapshot_page, snapshot_slot: out_snapshot_slot,
                page_erased: out_page_erased};
        sb.check_result(got);
      end
      if (holdoffs_seen != holdoff_requests) begin
        holdoffs_seen = holdoff_requests;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus: directed corner cases, then random phases with changing idle rates.
  initial begin
    int saved_pct;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue: get, unmatched remove, then the first snapshot by clearing.
    sender_idle_pct = 15;
    recv_idle_pct = 51;
    push_beat(pesr_pkg::OP_GET, '0, '0, 4'd0);
    push_beat(pesr_pkg::OP_REMOVE, 32'd5, '0, '0);
    push_beat(pesr_pkg::OP_CLEAR, '0, '0, '0);
    // Id assignment, extreme ids and payloads, reads in and out of range.
    push_beat(pesr_pkg::OP_ENQUEUE, '0, '0, '0);
    push_beat(pesr_pkg::OP_ENQUEUE, '1, '1, '1);
    push_beat(pesr_pkg::OP_GET, '1, '1, 4'd0);
    push_beat(pesr_pkg::OP_GET, '0, '0, 4'd1);
    push_beat(pesr_pkg::OP_GET, '0, '0, 4'd2);
    push_beat(pesr_pkg::OP_GET, '0, '0, 4'd15);
    // Full queue drops the oldest; duplicates then go out in one remove.
    push_beat(pesr_pkg::OP_ENQUEUE, 32'd7, 64'hA5A5_5A5A_F00D_0001, '0);
    push_beat(pesr_pkg::OP_ENQUEUE, 32'd7, 64'h0123_4567_89AB_CDEF, '0);
    push_beat(pesr_pkg::OP_REMOVE, 32'd7, '0, '0);
    push_beat(pesr_pkg::OP_GET, '0, '0, 4'd0);
    // Removes with no match leave the state alone; a matching one keeps order.
    push_beat(pesr_pkg::OP_ENQUEUE, 32'd9, 64'h1, '0);
    push_beat(pesr_pkg::OP_ENQUEUE, 32'h8000_0000, 64'h8000_0000_0000_0000, '0);
    push_beat(pesr_pkg::OP_REMOVE, '0, '0, '0);
    push_beat(pesr_pkg::OP_REMOVE, 32'h0001_2345, '0, '0);
    push_beat(pesr_pkg::OP_REMOVE, 32'd9, '0, '0);
    push_beat(pesr_pkg::OP_GET, '0, '0, 4'd0);
    push_beat(pesr_pkg::OP_CLEAR, '0, '0, '0);
    push_beat(pesr_pkg::OP_CLEAR, '0, '0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      sender_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 15 : 0;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
        // Long result-side stall while the sender keeps pushing, so in_full rises.
        if (phase == 0 && i == 100) begin
          holdoff_requests = holdoff_requests + 1;
          saved_pct = sender_idle_pct;
          sender_idle_pct = 0;
          repeat (24) random_beat();
          sender_idle_pct = saved_pct;
        end
        random_beat();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d enqueue, %0d remove, %0d clear and %0d get beats; %0d results checked.",
             sb.op_seen[pesr_pkg::OP_ENQUEUE], sb.op_seen[pesr_pkg::OP_REMOVE],
             sb.op_seen[pesr_pkg::OP_CLEAR], sb.op_seen[pesr_pkg::OP_GET], sb.results);
    $display("Saw %0d oldest-entry drops, %0d page erases, final generation %0d, %0d errors.",
             sb.drops, sb.erases, sb.gen, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("persistent_event_queue_slot_rotation_unit: match");
    end else begin
      $display("persistent_event_queue_slot_rotation_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pesr_pkg.sv
rtl/pesr_front.sv
rtl/pesr_back.sv
rtl/persistent_event_queue_slot_rotation_unit.sv
rtl/pesr_checker.sv
tb/sv/persistent_event_queue_slot_rotation_unit_tb.sv
